// ----- rtl/core/etc1_pkg.sv -----
// Shared types, constants and the modifier table of the ETC1 block decoder.
package etc1_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [63:0] block_bits;
    } blk_req_t;

    typedef struct packed {
        logic [1:0] texel_x;
        logic [1:0] texel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_texel;
    } texel_t;

    // [0] red, [1] green, [2] blue
    typedef logic [2:0][7:0] rgb_t;

    typedef struct packed {
        logic        flip;
        logic [2:0]  cw0;
        logic [2:0]  cw1;
        rgb_t        base0;
        rgb_t        base1;
        logic [31:0] idx;
    } blk_entry_t;

    // Intensity modifier for codeword cw and texel index sel = {msb, lsb}.
    function automatic logic signed [8:0] modifier(input logic [2:0] cw, input logic [1:0] sel);
        logic [7:0] small_mag;
        logic [7:0] large_mag;
        logic [7:0] mag;
        case (cw)
            3'd0:
            begin
                small_mag = 8'd2;
                large_mag = 8'd8;
            end
            3'd1:
            begin
                small_mag = 8'd5;
                large_mag = 8'd17;
            end
            3'd2:
            begin
                small_mag = 8'd9;
                large_mag = 8'd29;
            end
            3'd3:
            begin
                small_mag = 8'd13;
                large_mag = 8'd42;
            end
            3'd4:
            begin
                small_mag = 8'd18;
                large_mag = 8'd60;
            end
            3'd5:
            begin
                small_mag = 8'd24;
                large_mag = 8'd80;
            end
            3'd6:
            begin
                small_mag = 8'd33;
                large_mag = 8'd106;
            end
            default:
            begin
                small_mag = 8'd47;
                large_mag = 8'd183;
            end
        endcase
        mag = sel[0] ? large_mag : small_mag;
        return sel[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// ----- rtl/core/etc1_stream_if.sv -----
// Valid/ready stream channel carrying one request payload.
interface etc1_stream_if #(parameter type payload_t = logic [63:0]);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/etc1_front.sv -----
// Front end: accepts a block and resolves flip, codewords and both base colors.
module etc1_front (
    etc1_stream_if.sink             blk_in,
    input  logic                    full,
    output logic                    push,
    output etc1_pkg::blk_entry_t    entry
);
    import etc1_pkg::*;

    logic [31:0] ctl;

    function automatic logic [7:0] expand_diff(input logic [4:0] b, input logic [2:0] d);
        logic signed [6:0] s;
        logic [4:0]        v;
        s = $signed({2'b00, b}) + $signed({{4{d[2]}}, d});
        if (s < 7'sd0)
            v = 5'd0;
        else if (s > 7'sd31)
            v = 5'd31;
        else
            v = s[4:0];
        return {v, v[4:2]};
    endfunction

    assign ctl          = blk_in.data.block_bits[63:32];
    assign blk_in.ready = !full;
    assign push         = blk_in.valid && !full;

    always_comb
    begin
        entry.flip = ctl[0];
        entry.cw0  = ctl[7:5];
        entry.cw1  = ctl[4:2];
        entry.idx  = blk_in.data.block_bits[31:0];
        for (int ch = 0; ch < 3; ch++)
        begin
            if (ctl[1])
            begin
                entry.base0[ch] = {ctl[27-8*ch +: 5], ctl[29-8*ch +: 3]};
                entry.base1[ch] = expand_diff(ctl[27-8*ch +: 5], ctl[24-8*ch +: 3]);
            end
            else
            begin
                entry.base0[ch] = {ctl[28-8*ch +: 4], ctl[28-8*ch +: 4]};
                entry.base1[ch] = {ctl[24-8*ch +: 4], ctl[24-8*ch +: 4]};
            end
        end
    end

endmodule

// ----- rtl/core/etc1_queue.sv -----
// Small FIFO of resolved blocks between front and back end.
module etc1_queue #(
    parameter int Depth = etc1_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  etc1_pkg::blk_entry_t    wr_data,
    output logic                    full,
    input  logic                    pop,
    output etc1_pkg::blk_entry_t    rd_data,
    output logic                    empty
);
    import etc1_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    blk_entry_t          store_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = cnt_reg == CntW'(Depth);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- rtl/core/etc1_back.sv -----
// Back end: walks the 16 texels of a block and drives the texel output register.
module etc1_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  etc1_pkg::blk_entry_t    entry,
    input  logic                    empty,
    output logic                    pop,
    etc1_stream_if.source           texel_out
);
    import etc1_pkg::*;

    blk_entry_t         cur_reg, cur_next;
    logic               busy_reg, busy_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    texel_t             out_reg, out_next;
    logic               advance, finish;
    logic [1:0]         tx, ty;
    logic               lsb, msb, sub;
    logic [2:0]         cw;
    rgb_t               base;
    logic signed [8:0]  m;
    logic signed [9:0]  sum [3];
    rgb_t               chan;
    texel_t             texel;

    assign advance = busy_reg && (!out_valid_reg || texel_out.ready);
    assign finish  = advance && (cnt_reg == 4'd15);
    assign pop     = !empty && (!busy_reg || finish);

    assign texel_out.valid = out_valid_reg;
    assign texel_out.data  = out_reg;

    always_comb
    begin
        tx   = cnt_reg[1:0];
        ty   = cnt_reg[3:2];
        lsb  = cur_reg.idx[{1'b0, tx, ty}];
        msb  = cur_reg.idx[{1'b1, tx, ty}];
        sub  = cur_reg.flip ? ty[1] : tx[1];
        cw   = sub ? cur_reg.cw1 : cur_reg.cw0;
        base = sub ? cur_reg.base1 : cur_reg.base0;
        m    = modifier(cw, {msb, lsb});
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = $signed({2'b00, base[ch]}) + $signed({m[8], m});
            if (sum[ch] < 10'sd0)
                chan[ch] = 8'd0;
            else if (sum[ch] > 10'sd255)
                chan[ch] = 8'd255;
            else
                chan[ch] = sum[ch][7:0];
        end
        texel.texel_x    = tx;
        texel.texel_y    = ty;
        texel.red        = chan[0];
        texel.green      = chan[1];
        texel.blue       = chan[2];
        texel.last_texel = (cnt_reg == 4'd15);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
            cnt_next = cnt_reg + 4'd1;
        if (finish)
            busy_next = 1'b0;
        if (pop)
        begin
            busy_next = 1'b1;
            cur_next  = entry;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_next       = texel;
        end
        else if (texel_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

// ----- rtl/core/etc1_block_decoder.sv -----
// Top level of the ETC1 block decoder.
//
//  channel     dir   payload                                          per request
//  blk_in      in    block_bits[63:0]                                 one 4x4 block
//  texel_out   out   texel_x, texel_y, red, green, blue, last_texel  one texel
//
// One texel per cycle while texel_out is not stalled, set by the texel walk in the back end.
// The first texel passes the queue, the block register cur_reg and the output register.
// The queue holds QueueDepth resolved blocks, so blk_in keeps taking blocks while texels drain.
// A stalled texel holds in the output register; the walk pauses with it.
// Reset clears control state only; no clearing pass.
module etc1_block_decoder #(
    parameter int QueueDepth = etc1_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    etc1_stream_if.sink     blk_in,
    etc1_stream_if.source   texel_out
);
    import etc1_pkg::*;

    blk_entry_t push_entry;
    blk_entry_t head_entry;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    etc1_front u_front (
        .blk_in (blk_in),
        .full   (full),
        .push   (push),
        .entry  (push_entry)
    );

    etc1_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_entry),
        .full    (full),
        .pop     (pop),
        .rd_data (head_entry),
        .empty   (empty)
    );

    etc1_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .entry     (head_entry),
        .empty     (empty),
        .pop       (pop),
        .texel_out (texel_out)
    );

endmodule

// ----- rtl/core/etc1_checker.sv -----
// Port-level assertions for the ETC1 block decoder and their bind.
module etc1_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  etc1_pkg::texel_t    out_data
);
    import etc1_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("texel changed while stalled");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.last_texel == (out_data.texel_x == 2'd3 && out_data.texel_y == 2'd3))
        else $error("last_texel not on texel (3,3)");

    a_raster: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_texel |=>
            out_valid &&
            {out_data.texel_y, out_data.texel_x} ==
                $past({out_data.texel_y, out_data.texel_x}) + 4'd1)
        else $error("texel order broken within block");

endmodule

bind etc1_block_decoder etc1_checker u_etc1_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (texel_out.valid),
    .out_ready (texel_out.ready),
    .out_data  (texel_out.data)
);

// ----- tb/etc1_texel_checker.sv -----
// Checker for the ETC1 block decoder: predicts the texels of each block and compares them.
module etc1_texel_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              blk_valid,
    input  logic              blk_ready,
    input  etc1_pkg::blk_req_t blk_data,
    input  logic              texel_valid,
    input  logic              texel_ready,
    input  etc1_pkg::texel_t  texel_data,
    output int                errors,
    output int                pending,
    output int                blocks_seen,
    output int                texels_seen
);
    import etc1_pkg::*;

    localparam int MOD_MAG [8][2] = '{
        '{2, 8}, '{5, 17}, '{9, 29}, '{13, 42},
        '{18, 60}, '{24, 80}, '{33, 106}, '{47, 183}
    };

    texel_t texels_due[$];

    initial
    begin
        errors = 0;
        pending = 0;
        blocks_seen = 0;
        texels_seen = 0;
    end

    function automatic int expand5(int c);
        if (c < 0)
            c = 0;
        if (c > 31)
            c = 31;
        return (c << 3) | (c >> 2);
    endfunction

    function automatic logic [7:0] clamp8(int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic void decode_block(logic [63:0] blk);
        logic [31:0] ctl;
        logic [31:0] idx;
        logic [2:0]  cw [2];
        int          base [2][3];
        int          b5;
        int          d3;
        int          sub;
        int          pos;
        int          m;
        texel_t      t;
        ctl = blk[63:32];
        idx = blk[31:0];
        cw[0] = ctl[7:5];
        cw[1] = ctl[4:2];
        for (int ch = 0; ch < 3; ch++)
        begin
            if (ctl[1])
            begin
                b5 = (ctl >> (27 - 8 * ch)) & 32'h1f;
                d3 = $signed(3'((ctl >> (24 - 8 * ch)) & 32'h7));
                base[0][ch] = expand5(b5);
                base[1][ch] = expand5(b5 + d3);
            end
            else
            begin
                base[0][ch] = ((ctl >> (28 - 8 * ch)) & 32'hf) * 17;
                base[1][ch] = ((ctl >> (24 - 8 * ch)) & 32'hf) * 17;
            end
        end
        for (int y = 0; y < 4; y++)
        begin
            for (int x = 0; x < 4; x++)
            begin
                pos = x * 4 + y;
                sub = ctl[0] ? int'(y >= 2) : int'(x >= 2);
                m = MOD_MAG[cw[sub]][idx[pos]];
                if (idx[pos + 16])
                    m = -m;
                t.texel_x = x[1:0];
                t.texel_y = y[1:0];
                t.red = clamp8(base[sub][0] + m);
                t.green = clamp8(base[sub][1] + m);
                t.blue = clamp8(base[sub][2] + m);
                t.last_texel = (x == 3 && y == 3);
                texels_due.push_back(t);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        texel_t want;
        if (rst_n)
        begin
            if (blk_valid && blk_ready)
            begin
                decode_block(blk_data.block_bits);
                blocks_seen++;
            end
            if (texel_valid && texel_ready)
            begin
                texels_seen++;
                if (texels_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected texel x=%0d y=%0d rgb=%02h%02h%02h last=%0d",
                                 texel_data.texel_x, texel_data.texel_y, texel_data.red,
                                 texel_data.green, texel_data.blue, texel_data.last_texel);
                end
                else
                begin
                    want = texels_due.pop_front();
                    if (want.texel_x !== texel_data.texel_x
                        || want.texel_y !== texel_data.texel_y
                        || want.red !== texel_data.red
                        || want.green !== texel_data.green
                        || want.blue !== texel_data.blue
                        || want.last_texel !== texel_data.last_texel)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("texel mismatch: exp x=%0d y=%0d rgb=%02h%02h%02h last=%0d"
                                     , want.texel_x, want.texel_y, want.red, want.green,
                                     want.blue, want.last_texel);
                        if (errors <= 10)
                            $display("                got x=%0d y=%0d rgb=%02h%02h%02h last=%0d"
                                     , texel_data.texel_x, texel_data.texel_y, texel_data.red,
                                     texel_data.green, texel_data.blue, texel_data.last_texel);
                    end
                end
            end
            pending <= texels_due.size();
        end
    end

endmodule

// ----- tb/tb_etc1_block_decoder.sv -----
// Testbench top for the ETC1 block decoder: block stimulus, texel back-pressure and verdict.
module tb_etc1_block_decoder;
    import etc1_pkg::*;

    localparam int RANDOM_BLOCKS = 430;
    localparam int QUIET_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic no_stall;
    int   errors;
    int   pending;
    int   blocks_seen;
    int   texels_seen;
    int   quiet_cycles;

    etc1_stream_if #(.payload_t(blk_req_t)) blk_ch ();
    etc1_stream_if #(.payload_t(texel_t))   texel_ch ();

    etc1_block_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_in    (blk_ch),
        .texel_out (texel_ch)
    );

    etc1_texel_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .blk_valid   (blk_ch.valid),
        .blk_ready   (blk_ch.ready),
        .blk_data    (blk_ch.data),
        .texel_valid (texel_ch.valid),
        .texel_ready (texel_ch.ready),
        .texel_data  (texel_ch.data),
        .errors      (errors),
        .pending     (pending),
        .blocks_seen (blocks_seen),
        .texels_seen (texels_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            texel_ch.ready <= no_stall || ($urandom_range(99) >= 27);
    end

    always @(posedge clk)
    begin
        if ((blk_ch.valid && blk_ch.ready) || (texel_ch.valid && texel_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", quiet_cycles);
            $display("FAIL etc1_block_decoder");
            $finish;
        end
    end

    function automatic logic [63:0] make_block(logic [23:0] colors, logic [2:0] cw_a,
                                               logic [2:0] cw_b, logic diff, logic flip,
                                               logic [31:0] idx);
        return {colors, cw_a, cw_b, diff, flip, idx};
    endfunction

    // base/delta pairs and nibble pairs that drive the clamps
    function automatic logic [7:0] extreme_byte();
        case ($urandom_range(5))
            0: return 8'hFB;
            1: return 8'h04;
            2: return 8'hFF;
            3: return 8'h00;
            4: return 8'hF8;
            default: return 8'h07;
        endcase
    endfunction

    task automatic push_block(input logic [63:0] b);
        int gap;
        gap = 0;
        if (!no_stall)
            while ($urandom_range(99) < 27)
                gap++;
        if (gap > 0)
        begin
            blk_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blk_ch.valid <= 1'b1;
        blk_ch.data <= b;
        @(posedge clk);
        while (!blk_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] b;
        logic [31:0] patterns [4];
        clk = 1'b0;
        rst_n = 1'b0;
        no_stall = 1'b0;
        quiet_cycles = 0;
        blk_ch.valid = 1'b0;
        blk_ch.data = '0;
        texel_ch.ready = 1'b0;
        patterns = '{32'h0000FFFF, 32'hFFFF0000, 32'h5555AAAA, 32'hFFFFFFFF};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_block(64'h0);
        push_block({64{1'b1}});
        push_block(make_block(24'hFFFFFF, 3'd7, 3'd7, 1'b0, 1'b0, 32'h0000FFFF));
        push_block(make_block(24'h000000, 3'd7, 3'd7, 1'b0, 1'b1, 32'hFFFF0000));
        push_block(make_block(24'h000000, 3'd7, 3'd6, 1'b0, 1'b0, 32'hFFFFFFFF));
        // differential base plus delta past 31 and below 0
        push_block(make_block(24'hFBFBFB, 3'd0, 3'd7, 1'b1, 1'b0, 32'h0000FFFF));
        push_block(make_block(24'h040404, 3'd7, 3'd0, 1'b1, 1'b1, 32'hFFFFFFFF));
        push_block(make_block(24'hFC03FB, 3'd3, 3'd4, 1'b1, 1'b0, 32'h5555AAAA));
        push_block(make_block(24'h07F804, 3'd5, 3'd2, 1'b1, 1'b1, 32'h0F0F33CC));
        for (int cw = 0; cw < 8; cw++)
        begin
            b = make_block(24'($urandom), 3'(cw), 3'(7 - cw), cw[0], cw[1],
                           patterns[cw % 4]);
            push_block(b);
        end

        for (int n = 0; n < RANDOM_BLOCKS; n++)
        begin
            no_stall <= (n >= 200 && n < 280);
            b = {$urandom, $urandom};
            if ($urandom_range(3) == 0)
                b[63:40] = {extreme_byte(), extreme_byte(), extreme_byte()};
            push_block(b);
        end
        blk_ch.valid <= 1'b0;
        no_stall <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);

        $display("covered %0d blocks in both modes and both flips, %0d texels compared",
                 blocks_seen, texels_seen);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("PASS etc1_block_decoder");
        else
            $display("FAIL etc1_block_decoder");
        $finish;
    end

endmodule
